// ----- hw/rtl/isotp_rx_pkg.sv -----
// Shared constants, frame type codes and controller/datapath interface structs.
package isotp_rx_pkg;

  localparam int NUM_CHANNELS_DEF      = 4;
  localparam int MAX_MESSAGE_BYTES_DEF = 64;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  // PCI frame types (upper nibble of the first data byte)
  localparam logic [3:0] FT_SINGLE = 4'h0;
  localparam logic [3:0] FT_FIRST  = 4'h1;
  localparam logic [3:0] FT_CONSEC = 4'h2;

  localparam logic [2:0] FF_BYTES_LAST = 3'd4;  // five payload bytes in a first frame
  localparam logic [2:0] CF_MAX_BYTES  = 3'd7;
  localparam logic [3:0] FF_FIRST_SEQ  = 4'd1;
  localparam logic [7:0] SVC_RESP_BIT  = 8'h40;

  typedef struct packed {
    logic load_frame;
    logic cnt_clr;
    logic cnt_inc;
    logic ff_wr;
    logic cf_wr;
    logic ff_commit;
    logic cf_commit;
    logic out_load;
    logic out_sel_ram;
  } cmd_t;

  typedef struct packed {
    logic [3:0] pci_type;
    logic       chan_ok;
    logic       sf_len_zero;
    logic       sf_last;
    logic       ff_ok;
    logic       ff_last;
    logic       cf_ok;
    logic       cf_none;
    logic       cf_last;
    logic       cf_done;
    logic       rd_last;
    logic       out_free;
  } sts_t;

endpackage

// ----- hw/rtl/isotp_rx_ram.sv -----
// Generic simple dual-port RAM with registered read.
module isotp_rx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = isotp_rx_pkg::NUM_CHANNELS_DEF * isotp_rx_pkg::MAX_MESSAGE_BYTES_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/isotp_rx_datapath.sv -----
// Datapath: frame register, per-channel reassembly state, buffer RAM and output register.
module isotp_rx_datapath #(
  parameter int NUM_CHANNELS      = isotp_rx_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_MESSAGE_BYTES = isotp_rx_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [isotp_rx_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  isotp_rx_pkg::cmd_t                   cmd,
  output isotp_rx_pkg::sts_t                   sts,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [isotp_rx_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [isotp_rx_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                                 out_tlast
);

  localparam int LW    = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int DEPTH = NUM_CHANNELS * MAX_MESSAGE_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // captured frame
  logic [1:0] ch;
  logic [7:0] fb [8];

  // per-channel state
  logic          active [NUM_CHANNELS];
  logic [3:0]    seq    [NUM_CHANNELS];
  logic [LW-1:0] total  [NUM_CHANNELS];
  logic [LW-1:0] rcvd   [NUM_CHANNELS];
  logic [5:0]    svc    [NUM_CHANNELS];

  logic [LW-1:0] idx;

  logic [CHW-1:0] ch_idx;
  logic [AW-1:0]  ch_base;
  logic           chan_ok;
  logic [2:0]     idx3;

  logic [2:0]     sf_len;
  logic           sf_empty;
  logic           sf_req;
  logic [7:0]     sf_svc;
  logic [11:0]    ff_raw;
  logic [LW-1:0]  ff_total;
  logic [LW-1:0]  have;
  logic [LW-1:0]  want;
  logic [LW-1:0]  rem;
  logic [2:0]     cf_n;
  logic [LW:0]    have_sum;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  // output register fields
  logic [1:0] o_channel;
  logic       o_req;
  logic [7:0] o_svc;
  logic [7:0] o_payload;
  logic       o_bvalid;
  logic       o_last;

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      ch <= in_tdata[1:0];
      for (int i = 0; i < 8; i++) begin
        fb[i] <= in_tdata[2 + 8*i +: 8];
      end
    end
  end

  always_comb begin
    chan_ok  = 32'(ch) < 32'(NUM_CHANNELS);
    ch_idx   = chan_ok ? CHW'(ch) : '0;
    ch_base  = AW'(ch_idx) * AW'(MAX_MESSAGE_BYTES);
    idx3     = idx[2:0];

    sf_len   = fb[0][2:0];
    sf_empty = sf_len == 3'd1;
    sf_req   = (fb[1] & isotp_rx_pkg::SVC_RESP_BIT) == 8'd0;
    sf_svc   = sf_req ? fb[1] : {2'b00, fb[1][5:0]};

    ff_raw   = {fb[0][3:0], fb[1]};
    ff_total = LW'(ff_raw - 12'd1);

    have     = rcvd[ch_idx];
    want     = total[ch_idx];
    rem      = (want > have) ? want - have : '0;
    cf_n     = (rem > LW'(isotp_rx_pkg::CF_MAX_BYTES)) ? isotp_rx_pkg::CF_MAX_BYTES : rem[2:0];
    have_sum = (LW+1)'(have) + (LW+1)'(cf_n);
  end

  always_comb begin
    sts.pci_type    = fb[0][7:4];
    sts.chan_ok     = chan_ok;
    sts.sf_len_zero = sf_len == 3'd0;
    sts.sf_last     = sf_empty || (idx3 + 3'd2 == sf_len);
    sts.ff_ok       = (ff_raw >= 12'd8) && (ff_raw <= 12'(MAX_MESSAGE_BYTES + 1));
    sts.ff_last     = idx3 == isotp_rx_pkg::FF_BYTES_LAST;
    sts.cf_ok       = active[ch_idx] && (seq[ch_idx] == fb[0][3:0]);
    sts.cf_none     = cf_n == 3'd0;
    sts.cf_last     = idx3 + 3'd1 == cf_n;
    sts.cf_done     = have_sum >= (LW+1)'(want);
    sts.rd_last     = (idx + LW'(1)) == want;
    sts.out_free    = !out_tvalid || out_tready;
  end

  // byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.cnt_clr) begin
      idx <= '0;
    end else if (cmd.cnt_inc) begin
      idx <= idx + LW'(1);
    end
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        active[i] <= 1'b0;
        seq[i]    <= '0;
        total[i]  <= '0;
        rcvd[i]   <= '0;
        svc[i]    <= '0;
      end
    end else if (cmd.ff_commit) begin
      active[ch_idx] <= 1'b1;
      seq[ch_idx]    <= isotp_rx_pkg::FF_FIRST_SEQ;
      total[ch_idx]  <= ff_total;
      rcvd[ch_idx]   <= LW'(5);
      svc[ch_idx]    <= fb[2][5:0];
    end else if (cmd.cf_commit) begin
      seq[ch_idx]  <= fb[0][3:0] + 4'd1;
      rcvd[ch_idx] <= have_sum[LW-1:0];
      if (sts.cf_done) begin
        active[ch_idx] <= 1'b0;
      end
    end
  end

  always_comb begin
    ram_we    = cmd.ff_wr || cmd.cf_wr;
    ram_waddr = cmd.ff_wr ? ch_base + AW'(idx) : ch_base + AW'(have + idx);
    ram_wdata = cmd.ff_wr ? fb[3'd3 + idx3] : fb[3'd1 + idx3];
    ram_raddr = ch_base + AW'(idx);
  end

  isotp_rx_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_channel <= ch;
      if (cmd.out_sel_ram) begin
        o_req     <= 1'b0;
        o_svc     <= {2'b00, svc[ch_idx]};
        o_payload <= ram_rdata;
        o_bvalid  <= 1'b1;
        o_last    <= sts.rd_last;
      end else begin
        o_req     <= sf_req;
        o_svc     <= sf_svc;
        o_payload <= sf_empty ? 8'd0 : fb[3'd2 + idx3];
        o_bvalid  <= !sf_empty;
        o_last    <= sts.sf_last;
      end
    end
  end

  assign out_tdata = {6'd0, o_payload, o_svc, o_channel};
  assign out_tuser = {o_bvalid, o_req};
  assign out_tlast = o_last;

endmodule

// ----- hw/rtl/isotp_rx_ctrl.sv -----
// Controller: frame decode and sequencing of writes, reads and result emission.
module isotp_rx_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  isotp_rx_pkg::sts_t sts,
  output isotp_rx_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_SF_EMIT   = 3'd2;
  localparam logic [2:0] S_FF_WRITE  = 3'd3;
  localparam logic [2:0] S_CF_WRITE  = 3'd4;
  localparam logic [2:0] S_CF_COMMIT = 3'd5;
  localparam logic [2:0] S_RD_ADDR   = 3'd6;
  localparam logic [2:0] S_RD_EMIT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_tready  = state == S_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_frame = 1'b1;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.cnt_clr = 1'b1;
        state_next  = S_IDLE;
        if (sts.chan_ok) begin
          unique case (sts.pci_type)
            isotp_rx_pkg::FT_SINGLE: begin
              if (!sts.sf_len_zero) state_next = S_SF_EMIT;
            end
            isotp_rx_pkg::FT_FIRST: begin
              if (sts.ff_ok) state_next = S_FF_WRITE;
            end
            isotp_rx_pkg::FT_CONSEC: begin
              if (sts.cf_ok) state_next = sts.cf_none ? S_CF_COMMIT : S_CF_WRITE;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SF_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.cnt_inc  = 1'b1;
          if (sts.sf_last) state_next = S_IDLE;
        end
      end
      S_FF_WRITE: begin
        cmd.ff_wr   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.ff_last) begin
          cmd.ff_commit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CF_WRITE: begin
        cmd.cf_wr   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cf_last) state_next = S_CF_COMMIT;
      end
      S_CF_COMMIT: begin
        cmd.cf_commit = 1'b1;
        cmd.cnt_clr   = 1'b1;
        state_next    = sts.cf_done ? S_RD_ADDR : S_IDLE;
      end
      S_RD_ADDR: begin
        state_next = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_sel_ram = 1'b1;
          cmd.cnt_inc     = 1'b1;
          state_next      = sts.rd_last ? S_IDLE : S_RD_ADDR;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // never overwrite a result that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register busy");

  // read data is only used after its address has been presented
  a_rd_order: assert property (@(posedge clk) disable iff (rst)
    state == S_RD_EMIT |-> ($past(state) == S_RD_ADDR || $past(state) == S_RD_EMIT))
    else $error("buffer read emitted without address cycle");

  // buffer writes and buffer reads to the output never overlap
  a_wr_rd_excl: assert property (@(posedge clk) disable iff (rst)
    (cmd.ff_wr || cmd.cf_wr) |-> !cmd.out_load)
    else $error("buffer write during result emission");

  // a captured frame is always decoded on the next cycle
  a_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load_frame |=> state == S_DECODE)
    else $error("frame capture not followed by decode");

endmodule

// ----- hw/rtl/isotp_receive_reassembler.sv -----
// Top level of the ISO-TP receive reassembler: stream ports, controller and datapath.
// A single frame is decoded after acceptance, then its words go out one per cycle while the
//   output register is free; first and consecutive frames are written into the buffer, and a
//   completed message is read back byte by byte (one buffer RAM read port, registered read).
// s_axis_tready is high only while idle; a stalled output word holds emission and the input.
// Reset (rst, synchronous): clears channel state, counter and output valid; buffer not cleared.
module isotp_receive_reassembler #(
  parameter int NUM_CHANNELS      = isotp_rx_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_MESSAGE_BYTES = isotp_rx_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // tdata: channel[1:0], frame_byte_0[9:2], frame_byte_1[17:10], ... frame_byte_7[65:58],
  //        zero fill [71:66]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [isotp_rx_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: out_channel[1:0], svc_id[9:2], payload_byte[17:10], zero fill [23:18]
  output logic [isotp_rx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: is_request[0], byte_valid[1]
  output logic [isotp_rx_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                                 m_axis_tlast
);

  isotp_rx_pkg::cmd_t cmd;
  isotp_rx_pkg::sts_t sts;

  // Controller: decode the captured frame, then sequence buffer writes, the
  // per-channel state update, buffer reads and loading of the output register.
  isotp_rx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds the frame, channel tables, message buffer and the output
  // word register that parts the block from the downstream consumer.
  isotp_rx_datapath #(
    .NUM_CHANNELS      (NUM_CHANNELS),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_tdata   (s_axis_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tuser  (m_axis_tuser),
    .out_tlast  (m_axis_tlast)
  );

endmodule
